>>> design/fac_pkg.sv
// Shared types and codes for the fixed array list engine.
// No dependencies; imported by the cell, the chain and the top level.
package fac_pkg;

    // Operation codes carried by the func field of an input item
    localparam logic [2:0] FN_READ        = 3'd0;
    localparam logic [2:0] FN_WRITE       = 3'd1;
    localparam logic [2:0] FN_INSERT_AT   = 3'd2;
    localparam logic [2:0] FN_APPEND      = 3'd3;
    localparam logic [2:0] FN_REMOVE_AT   = 3'd4;
    localparam logic [2:0] FN_REMOVE_LAST = 3'd5;
    localparam logic [2:0] FN_SORTED_INS  = 3'd6;
    localparam logic [2:0] FN_REVERSE     = 3'd7;

    // Status codes returned with every result item
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    localparam int DATA_W  = 8;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    // Per-cycle command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SORTED,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   data;
    } cell_cmd_t;

    // Control sequencer states
    typedef enum logic {
        S_IDLE,
        S_REV
    } state_t;

endpackage

>>> design/fac_cell.sv
// One element cell of the list chain: holds a byte and its next value.
// Depends on fac_pkg for the broadcast command type.
module fac_cell #(
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fac_pkg::cell_cmd_t         cmd,
    input  logic [CW-1:0]              k,
    input  logic [CW-1:0]              count,
    input  logic [fac_pkg::DATA_W-1:0] left_data,
    input  logic [fac_pkg::DATA_W-1:0] right_data,
    input  logic                       passed_in,
    output logic [fac_pkg::DATA_W-1:0] data,
    output logic                       passed_out
);
    import fac_pkg::*;

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              gt;

    // Sorted insert: the first cell past the list or above the new byte takes it
    assign gt         = (IDX_C >= count) || (data_reg > cmd.data);
    assign passed_out = passed_in | gt;
    assign data       = data_reg;

    // Select the next byte from the broadcast command and the neighbors
    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            CELL_WRITE: begin
                if (IDX_C == k) data_next = cmd.data;
            end
            CELL_INSERT: begin
                if (IDX_C == k) data_next = cmd.data;
                else if (IDX_C > k && IDX_C <= count) data_next = left_data;
            end
            CELL_REMOVE: begin
                if (IDX_P1 == count) data_next = '0;
                else if (IDX_C >= k && IDX_P1 < count) data_next = right_data;
            end
            CELL_SORTED: begin
                if (!passed_in && gt) data_next = cmd.data;
                else if (passed_in && IDX_C <= count) data_next = left_data;
            end
            CELL_ROTATE: begin
                if (IDX_C < k) data_next = right_data;
                else if (IDX_C == k) data_next = cmd.data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

endmodule

>>> design/fac_chain.sv
// Row of element cells with neighbor links and the positional read select.
// Depends on fac_pkg and fac_cell.
module fac_chain #(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fac_pkg::cell_cmd_t         cmd,
    input  logic [CW-1:0]              k,
    input  logic [CW-1:0]              count,
    input  logic [CW-1:0]              rd_pos,
    output logic [fac_pkg::DATA_W-1:0] rd_data,
    output logic [fac_pkg::DATA_W-1:0] head_data,
    output logic                       sort_hit
);
    import fac_pkg::*;

    logic [DATA_W-1:0] data_w   [CAPACITY];
    logic              passed_w [CAPACITY];

    // Build the row; the ends see zero bytes and no upstream hit
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        logic              pass_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
            assign pass_d = 1'b0;
        end else begin : g_mid
            assign left_d = data_w[i-1];
            assign pass_d = passed_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_inner
            assign right_d = data_w[i+1];
        end

        fac_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .k          (k),
            .count      (count),
            .left_data  (left_d),
            .right_data (right_d),
            .passed_in  (pass_d),
            .data       (data_w[i]),
            .passed_out (passed_w[i])
        );
    end

    // Pick the byte at the read position
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (rd_pos == CW'(i)) rd_data = rd_data | data_w[i];
        end
    end

    assign head_data = data_w[0];
    assign sort_hit  = passed_w[CAPACITY-1];

endmodule

>>> design/fixed_array_list_engine_unit.sv
// Top level of the fixed array list engine: sequencer, count and result register.
// Depends on fac_pkg and fac_chain (which holds the fac_cell row).
//
//   channel | direction | ports                                  | handshake
//   s_      | in        | s_func, s_position, s_data_in          | s_valid / s_ready
//   m_      | out       | m_read_data, m_status, m_count         | m_valid / m_ready
//
// Every operation but reverse is applied to the cell row as the item is taken; the result is
// registered and shows on m_ the cycle after the item is taken.
// Reverse of n entries takes n-1 rotate steps (n >= 2) through the cell row;
// s_ready is low during them.
// aresetn is synchronous: it clears all cells, the count and the result valid.
// A held result blocks the next item until m_ready takes it or frees the slot.
module fixed_array_list_engine_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_func,
    input  logic [fac_pkg::POS_W-1:0]   s_position,
    input  logic [fac_pkg::DATA_W-1:0]  s_data_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fac_pkg::DATA_W-1:0]  m_read_data,
    output logic [1:0]                  m_status,
    output logic [fac_pkg::COUNT_W-1:0] m_count
);
    import fac_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    state_t state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      t_reg, t_next;
    logic               m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]  rd_reg;
    logic [1:0]         st_reg;
    logic [COUNT_W-1:0] cnt_out_reg;

    logic               accept;
    logic               full, empty, in_range, short_list;
    logic [CW-1:0]      pos_k;
    cell_cmd_t          cmd;
    logic [CW-1:0]      cmd_k;
    logic               out_load;
    logic [DATA_W-1:0]  res_rd;
    logic [1:0]         res_st;
    logic [DATA_W-1:0]  rd_data, head_data;
    logic               sort_hit;

    assign s_ready  = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == CAP_C);
    assign empty    = (count_reg == '0);
    assign in_range = CMPW'(s_position) < CMPW'(count_reg);
    assign pos_k    = CW'(s_position);
    assign short_list = (count_reg < CW'(2));

    // Next state of the sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && s_func == FN_REVERSE && !short_list) state_next = S_REV;
            end
            S_REV: begin
                if (t_reg == ONE_C) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Decode the item into a cell command, new count and result fields
    always_comb begin
        cmd.op     = CELL_HOLD;
        cmd.data   = s_data_in;
        cmd_k      = pos_k;
        count_next = count_reg;
        t_next     = t_reg;
        out_load   = 1'b0;
        res_rd     = '0;
        res_st     = STAT_OK;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    out_load = 1'b1;
                    case (s_func)
                        FN_READ: begin
                            if (in_range) res_rd = rd_data;
                            else res_st = STAT_RANGE;
                        end
                        FN_WRITE: begin
                            if (in_range) cmd.op = CELL_WRITE;
                            else res_st = STAT_RANGE;
                        end
                        FN_INSERT_AT: begin
                            if (full) begin
                                res_st = STAT_FULL;
                            end else if (empty) begin
                                cmd.op     = CELL_INSERT;
                                cmd_k      = '0;
                                count_next = count_reg + ONE_C;
                            end else if (!in_range) begin
                                res_st = STAT_RANGE;
                            end else begin
                                cmd.op     = CELL_INSERT;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        FN_APPEND: begin
                            if (full) begin
                                res_st = STAT_FULL;
                            end else begin
                                cmd.op     = CELL_INSERT;
                                cmd_k      = count_reg;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        FN_REMOVE_AT: begin
                            if (!in_range) begin
                                res_st = STAT_RANGE;
                            end else begin
                                cmd.op     = CELL_REMOVE;
                                count_next = count_reg - ONE_C;
                            end
                        end
                        FN_REMOVE_LAST: begin
                            if (empty) begin
                                res_st = STAT_EMPTY;
                            end else begin
                                cmd.op     = CELL_REMOVE;
                                cmd_k      = count_reg - ONE_C;
                                count_next = count_reg - ONE_C;
                            end
                        end
                        FN_SORTED_INS: begin
                            if (full) begin
                                res_st = STAT_FULL;
                            end else begin
                                cmd.op     = CELL_SORTED;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        FN_REVERSE: begin
                            // Short lists are already reversed; longer ones rotate
                            if (!short_list) begin
                                out_load = 1'b0;
                                t_next   = count_reg - ONE_C;
                            end
                        end
                        default: res_st = STAT_OK;
                    endcase
                end
            end
            S_REV: begin
                // Move the head into slot t and pull the cells below it down
                cmd.op   = CELL_ROTATE;
                cmd.data = head_data;
                cmd_k    = t_reg;
                t_next   = t_reg - ONE_C;
                out_load = (t_reg == ONE_C);
            end
            default: cmd.op = CELL_HOLD;
        endcase
    end

    // Hold a result until it is taken
    always_comb begin
        if (out_load) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

    fac_chain #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .k         (cmd_k),
        .count     (count_reg),
        .rd_pos    (pos_k),
        .rd_data   (rd_data),
        .head_data (head_data),
        .sort_hit  (sort_hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload and rotate target need no reset
    always_ff @(posedge aclk) begin
        t_reg <= t_next;
        if (out_load) begin
            rd_reg      <= res_rd;
            st_reg      <= res_st;
            cnt_out_reg <= COUNT_W'(count_next);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = rd_reg;
    assign m_status    = st_reg;
    assign m_count     = cnt_out_reg;

    // Count never passes the capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("list count above capacity");

    // No new item is taken while a reverse is rotating
    a_rev_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REV) |-> !s_ready)
        else $error("item accepted during reverse");

    // Reverse leaves the count alone
    a_rev_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REV) |=> (count_reg == $past(count_reg)))
        else $error("count changed during reverse");

    // A held result is never overwritten
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !out_load)
        else $error("result overwritten before taken");

    // Sorted insert into a list with room always finds a slot in the row
    a_sort_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func == FN_SORTED_INS && !full) |-> sort_hit)
        else $error("sorted insert found no slot");

endmodule
